// File: src/tksl_pkg.sv
// Shared types and constants for the bounded top-k sorted list.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package tksl_pkg;

  // Field widths fixed by the item format
  localparam int unsigned KeyW     = 32;
  localparam int unsigned TagW     = 16;
  localparam int unsigned CountW   = 7;
  localparam int unsigned PosW     = 6;
  localparam int unsigned RidxW    = 6;
  localparam int unsigned FuncW    = 2;
  localparam int unsigned DepthDef = 64;

  // Configuration port
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;
  localparam logic [CountW-1:0] CapacityRst = 7'd64;

  // Request operation codes; the fourth code is a no-op
  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_e;

  // Register indexes (paddr[2])
  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_MODE     = 1'b1
  } reg_e;

  // Memory read address source
  typedef enum logic [1:0] {
    RD_SCAN  = 2'd0,
    RD_SHIFT = 2'd1,
    RD_INDEX = 2'd2
  } rd_sel_e;

  // One stored list entry
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag_first;
    logic [TagW-1:0] tag_second;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    scan_next;
    logic    shift_init;
    logic    shift_wr;
    logic    place;
    logic    load_result;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_insert;
    logic is_read;
    logic scan_end;
    logic better;
    logic shift_done;
    logic room;
  } dp_stat_t;

endpackage

// File: src/tksl_if.sv
// Request and response channel interfaces of the top-k sorted list.
// Depends on tksl_pkg for field widths.
`timescale 1ns / 1ps

interface tksl_req_if;
  import tksl_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [FuncW-1:0]        func;
  logic signed [KeyW-1:0]  value;
  logic [TagW-1:0]         tag_first;
  logic [TagW-1:0]         tag_second;
  logic [RidxW-1:0]        read_index;

  modport source (
    output valid, func, value, tag_first, tag_second, read_index,
    input  ready
  );

  modport sink (
    input  valid, func, value, tag_first, tag_second, read_index,
    output ready
  );
endinterface

interface tksl_rsp_if;
  import tksl_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    accepted;
  logic [PosW-1:0]         position;
  logic [CountW-1:0]       count;
  logic                    read_valid;
  logic signed [KeyW-1:0]  read_value;
  logic [TagW-1:0]         read_tag_first;
  logic [TagW-1:0]         read_tag_second;

  modport source (
    output valid, accepted, position, count, read_valid, read_value,
           read_tag_first, read_tag_second,
    input  ready
  );

  modport sink (
    input  valid, accepted, position, count, read_valid, read_value,
           read_tag_first, read_tag_second,
    output ready
  );
endinterface

// File: src/tksl_cfg.sv
// APB-style configuration registers: capacity and ordering mode.
// Depends on tksl_pkg.
`timescale 1ns / 1ps

module tksl_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tksl_pkg::PaddrW-1:0]   paddr,
  input  logic [tksl_pkg::PdataW-1:0]   pwdata,
  output logic [tksl_pkg::PdataW-1:0]   prdata,
  output logic                          pready,
  output logic [tksl_pkg::CountW-1:0]   capacity_o,
  output logic                          keep_smallest_o
);
  import tksl_pkg::*;

  logic [CountW-1:0] capacity_q;
  logic              mode_q;
  logic              wr_en;
  reg_e              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_e'(paddr[2]);

  // Write on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapacityRst;
      mode_q     <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_CAPACITY: capacity_q <= pwdata[CountW-1:0];
        REG_MODE:     mode_q     <= pwdata[0];
        default:      ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_CAPACITY: prdata = PdataW'(capacity_q);
      REG_MODE:     prdata = PdataW'(mode_q);
      default:      prdata = '0;
    endcase
  end

  assign capacity_o      = capacity_q;
  assign keep_smallest_o = mode_q;

endmodule

// File: src/tksl_dp.sv
// Datapath of the top-k sorted list: entry memory, scan and shift pointers,
// held count and the response register. Depends on tksl_pkg.
`timescale 1ns / 1ps

module tksl_dp #(
  parameter int unsigned Depth = tksl_pkg::DepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tksl_pkg::ctrl_cmd_t           cmd_i,
  output tksl_pkg::dp_stat_t            stat_o,
  input  logic [tksl_pkg::CountW-1:0]   capacity_i,
  input  logic                          keep_smallest_i,
  input  logic [tksl_pkg::FuncW-1:0]    func_i,
  input  logic [tksl_pkg::KeyW-1:0]     value_i,
  input  logic [tksl_pkg::TagW-1:0]     tag_first_i,
  input  logic [tksl_pkg::TagW-1:0]     tag_second_i,
  input  logic [tksl_pkg::RidxW-1:0]    read_index_i,
  output logic                          accepted_o,
  output logic [tksl_pkg::PosW-1:0]     position_o,
  output logic [tksl_pkg::CountW-1:0]   count_o,
  output logic                          read_valid_o,
  output logic [tksl_pkg::KeyW-1:0]     read_value_o,
  output logic [tksl_pkg::TagW-1:0]     read_tag_first_o,
  output logic [tksl_pkg::TagW-1:0]     read_tag_second_o
);
  import tksl_pkg::*;

  localparam int unsigned IdxW = $clog2(Depth);

  // Captured request
  logic [FuncW-1:0]  func_q;
  entry_t            new_q;
  logic [RidxW-1:0]  ridx_q;

  // Control state
  logic [CountW-1:0] held_q, held_d;
  logic [CountW-1:0] p_q, p_d;
  logic [CountW-1:0] k_q, k_d;
  logic              placed_q, placed_d;

  // Memory
  entry_t            mem_q [Depth];
  entry_t            rdata_q;
  logic [IdxW-1:0]   raddr;
  logic              we;
  logic [IdxW-1:0]   waddr;
  entry_t            wdata;

  logic [CountW-1:0] cap_eff;
  logic [CountW-1:0] last_idx;
  logic              read_ok;
  logic              is_insert;
  logic              is_read;
  logic              key_better;

  // Response register
  logic              acc_q;
  logic [PosW-1:0]   pos_q;
  logic [CountW-1:0] cnt_q;
  logic              rv_q;
  entry_t            rent_q;

  // Effective capacity: zero acts as one, clamp to the memory depth
  always_comb begin
    if (capacity_i == '0) begin
      cap_eff = CountW'(1);
    end else if (int'(capacity_i) > int'(Depth)) begin
      cap_eff = CountW'(Depth);
    end else begin
      cap_eff = capacity_i;
    end
  end

  // Highest slot touched by a shift
  assign last_idx = (int'(held_q) >= int'(Depth)) ? CountW'(Depth - 1) : held_q;

  assign is_insert = (func_q == FUNC_INSERT);
  assign is_read   = (func_q == FUNC_READ);
  assign read_ok   = ({1'b0, ridx_q} < held_q);

  // Rank compare against the entry just read
  assign key_better = keep_smallest_i ?
                      ($signed(new_q.key) < $signed(rdata_q.key)) :
                      ($signed(new_q.key) > $signed(rdata_q.key));

  assign stat_o.is_insert  = is_insert;
  assign stat_o.is_read    = is_read;
  assign stat_o.scan_end   = (p_q == held_q);
  assign stat_o.better     = key_better;
  assign stat_o.shift_done = (k_q == p_q);
  assign stat_o.room       = (held_q < cap_eff);

  // Capture the request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q            <= func_i;
      new_q.key         <= value_i;
      new_q.tag_first   <= tag_first_i;
      new_q.tag_second  <= tag_second_i;
      ridx_q            <= read_index_i;
    end
  end

  // Pointers, count and placement flag
  always_comb begin
    held_d   = held_q;
    p_d      = p_q;
    k_d      = k_q;
    placed_d = placed_q;
    if (cmd_i.capture) begin
      p_d      = '0;
      placed_d = 1'b0;
      if (func_i == FUNC_CLEAR) begin
        held_d = '0;
      end
    end
    if (cmd_i.scan_next) begin
      p_d = p_q + CountW'(1);
    end
    if (cmd_i.shift_init) begin
      k_d = last_idx;
    end
    if (cmd_i.shift_wr) begin
      k_d = k_q - CountW'(1);
    end
    if (cmd_i.place) begin
      placed_d = 1'b1;
      if (held_q < cap_eff) begin
        held_d = held_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      p_q      <= '0;
      k_q      <= '0;
      placed_q <= 1'b0;
    end else begin
      held_q   <= held_d;
      p_q      <= p_d;
      k_q      <= k_d;
      placed_q <= placed_d;
    end
  end

  // Select the read address
  always_comb begin
    case (cmd_i.rd_sel)
      RD_SCAN:  raddr = IdxW'(p_q);
      RD_SHIFT: raddr = IdxW'(k_q - CountW'(1));
      RD_INDEX: raddr = IdxW'(ridx_q);
      default:  raddr = '0;
    endcase
  end

  // Select the write: move one entry down, or drop the new entry in place
  always_comb begin
    we    = cmd_i.shift_wr | cmd_i.place;
    waddr = cmd_i.place ? IdxW'(p_q) : IdxW'(k_q);
    wdata = cmd_i.place ? new_q : rdata_q;
  end

  // Entry memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Load the response
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      acc_q  <= placed_q;
      pos_q  <= placed_q ? PosW'(p_q) : '0;
      cnt_q  <= held_q;
      rv_q   <= is_read & read_ok;
      rent_q <= (is_read && read_ok) ? rdata_q : '0;
    end
  end

  assign accepted_o        = acc_q;
  assign position_o        = pos_q;
  assign count_o           = cnt_q;
  assign read_valid_o      = rv_q;
  assign read_value_o      = rent_q.key;
  assign read_tag_first_o  = rent_q.tag_first;
  assign read_tag_second_o = rent_q.tag_second;

endmodule

// File: src/tksl_ctrl.sv
// Controller of the top-k sorted list: sequences scan, shift and placement,
// and owns both handshakes. Depends on tksl_pkg.
`timescale 1ns / 1ps

module tksl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  tksl_pkg::dp_stat_t   stat_i,
  output tksl_pkg::ctrl_cmd_t  cmd_o
);
  import tksl_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_SCAN_CHK  = 7'b0000010,
    ST_SCAN_CMP  = 7'b0000100,
    ST_SHIFT_CHK = 7'b0001000,
    ST_SHIFT_WR  = 7'b0010000,
    ST_PLACE     = 7'b0100000,
    ST_DONE      = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.rd_sel = RD_SCAN;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (stat_i.is_insert) begin
          if (stat_i.scan_end) begin
            state_d = stat_i.room ? ST_PLACE : ST_DONE;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_SCAN;
            state_d      = ST_SCAN_CMP;
          end
        end else if (stat_i.is_read) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_INDEX;
          state_d      = ST_DONE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN_CMP: begin
        if (stat_i.better) begin
          cmd_o.shift_init = 1'b1;
          state_d          = ST_SHIFT_CHK;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = ST_SCAN_CHK;
        end
      end
      ST_SHIFT_CHK: begin
        if (stat_i.shift_done) begin
          state_d = ST_PLACE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_SHIFT;
          state_d      = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = ST_SHIFT_CHK;
      end
      ST_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the response register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Response valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/bounded_top_k_sorted_list.sv
// Top level of the bounded top-k sorted list: configuration registers,
// controller and datapath. Depends on tksl_pkg and tksl_if.
//
//   Channel   Direction  Protocol        Carries
//   req_i     in         valid/ready     func, value, tag_first, tag_second, read_index
//   rsp_o     out        valid/ready     accepted, position, count, read_valid, read_*
//   apb       in         APB write/read  capacity (0x0), keep_smallest (0x4)
//
// One request is in work at a time. A read, clear or no-op goes from ST_SCAN_CHK
// straight to ST_DONE. An insert scans the entries that it does not beat; if it goes
// in ahead of an entry, later entries move down one slot before it is placed, else it
// is appended when there is room and dropped when there is none. The scan reads each
// entry in ST_SCAN_CHK, compares it in ST_SCAN_CMP; the shift reads in ST_SHIFT_CHK
// and writes in ST_SHIFT_WR. Reset empties the list at once; there is no clearing pass.
// The next request is taken while a response still waits in the output
// register; a stalled response holds the controller only at its last step.
`timescale 1ns / 1ps

module bounded_top_k_sorted_list #(
  parameter int unsigned Depth = tksl_pkg::DepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tksl_req_if.sink                      req_i,
  tksl_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tksl_pkg::PaddrW-1:0]   paddr,
  input  logic [tksl_pkg::PdataW-1:0]   pwdata,
  output logic [tksl_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);
  import tksl_pkg::*;

  logic [CountW-1:0] capacity;
  logic              keep_smallest;
  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic [KeyW-1:0]   read_value;

  // Configuration registers
  tksl_cfg u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .capacity_o      (capacity),
    .keep_smallest_o (keep_smallest)
  );

  // Sequencer
  tksl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Entry store and response
  tksl_dp #(
    .Depth (Depth)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .capacity_i        (capacity),
    .keep_smallest_i   (keep_smallest),
    .func_i            (req_i.func),
    .value_i           (req_i.value),
    .tag_first_i       (req_i.tag_first),
    .tag_second_i      (req_i.tag_second),
    .read_index_i      (req_i.read_index),
    .accepted_o        (rsp_o.accepted),
    .position_o        (rsp_o.position),
    .count_o           (rsp_o.count),
    .read_valid_o      (rsp_o.read_valid),
    .read_value_o      (read_value),
    .read_tag_first_o  (rsp_o.read_tag_first),
    .read_tag_second_o (rsp_o.read_tag_second)
  );

  assign rsp_o.read_value = $signed(read_value);

endmodule

// File: sim/bounded_top_k_sorted_list_test.sv
// Self-checking testbench for the bounded top-k sorted list: directed and random requests,
// APB capacity and mode changes between phases, random idling on both channels.
// Depends on tksl_pkg, tksl_if and the bounded_top_k_sorted_list RTL.
`timescale 1ns / 1ps

module bounded_top_k_sorted_list_test;
  import tksl_pkg::*;

  localparam int unsigned ListDepth     = DepthDef;
  localparam logic [FuncW-1:0] FuncNoop = 2'd3;
  localparam int unsigned PhaseRequests = 130;
  localparam int unsigned Phases        = 10;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned TailCycles    = 300;
  localparam int unsigned MaxReports    = 50;

  typedef struct packed {
    logic [FuncW-1:0]       func;
    logic signed [KeyW-1:0] value;
    logic [TagW-1:0]        tag_first;
    logic [TagW-1:0]        tag_second;
    logic [RidxW-1:0]       read_index;
  } list_request_t;

  typedef struct packed {
    logic                   accepted;
    logic [PosW-1:0]        position;
    logic [CountW-1:0]      count;
    logic                   read_valid;
    logic signed [KeyW-1:0] read_value;
    logic [TagW-1:0]        read_tag_first;
    logic [TagW-1:0]        read_tag_second;
  } list_result_t;

  // Shadow copy of the list; predicts each response and checks it in order
  class sorted_list_tracker;
    logic signed [KeyW-1:0] keys [ListDepth];
    logic [TagW-1:0]        first_tags [ListDepth];
    logic [TagW-1:0]        second_tags [ListDepth];
    int unsigned            held = 0;
    logic [CountW-1:0]      capacity = CapacityRst;
    logic                   keep_smallest = 1'b0;
    list_result_t           expected_q [$];
    int unsigned            errors = 0;

    function void write_register(reg_e idx, logic [PdataW-1:0] data);
      case (idx)
        REG_CAPACITY: capacity = data[CountW-1:0];
        REG_MODE:     keep_smallest = data[0];
        default: ;
      endcase
    endfunction

    // strictly better rank under the current mode
    function bit outranks(logic signed [KeyW-1:0] a, logic signed [KeyW-1:0] b);
      return keep_smallest ? (a < b) : (a > b);
    endfunction

    function void note_request(list_request_t r);
      list_result_t want;
      int lim;
      int p;
      int last;
      want = '0;
      lim = (capacity == 0) ? 1 : ((capacity > ListDepth) ? ListDepth : int'(capacity));
      case (r.func)
        FUNC_INSERT: begin
          // find the first entry that the new key beats
          p = 0;
          while (p < held && !outranks(r.value, keys[p])) p++;
          if (p < held || held < lim) begin
            last = (held >= ListDepth) ? ListDepth - 1 : held;
            for (int k = last; k > p; k--) begin
              keys[k]        = keys[k-1];
              first_tags[k]  = first_tags[k-1];
              second_tags[k] = second_tags[k-1];
            end
            keys[p]        = r.value;
            first_tags[p]  = r.tag_first;
            second_tags[p] = r.tag_second;
            if (held < lim) held++;
            want.accepted = 1'b1;
            want.position = PosW'(p);
          end
        end
        FUNC_READ: begin
          if (r.read_index < held) begin
            want.read_valid      = 1'b1;
            want.read_value      = keys[r.read_index];
            want.read_tag_first  = first_tags[r.read_index];
            want.read_tag_second = second_tags[r.read_index];
          end
        end
        FUNC_CLEAR: held = 0;
        default: ;
      endcase
      want.count = CountW'(held);
      expected_q.push_back(want);
    endfunction

    task report(string msg);
      if (errors < MaxReports) $display("%0t ns: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic [KeyW-1:0] got, logic [KeyW-1:0] want);
      if (got !== want) report($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    task check_response(list_result_t got);
      list_result_t want;
      if (expected_q.size() == 0) begin
        report("response with no request pending");
        return;
      end
      want = expected_q.pop_front();
      compare_field("accepted", got.accepted, want.accepted);
      compare_field("position", got.position, want.position);
      compare_field("count", got.count, want.count);
      compare_field("read_valid", got.read_valid, want.read_valid);
      compare_field("read_value", got.read_value, want.read_value);
      compare_field("read_tag_first", got.read_tag_first, want.read_tag_first);
      compare_field("read_tag_second", got.read_tag_second, want.read_tag_second);
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  tksl_req_if req_if ();
  tksl_rsp_if rsp_if ();

  sorted_list_tracker tracker;
  bit                 sender_bursts = 1'b0;

  bounded_top_k_sorted_list i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic list_request_t make_request(logic [FuncW-1:0] func,
                                                 logic signed [KeyW-1:0] value,
                                                 logic [TagW-1:0] t1, logic [TagW-1:0] t2,
                                                 logic [RidxW-1:0] idx);
    list_request_t r;
    r.func       = func;
    r.value      = value;
    r.tag_first  = t1;
    r.tag_second = t2;
    r.read_index = idx;
    return r;
  endfunction

  // Offer one request after a random gap; hold valid high across back-to-back requests
  task automatic send_request(list_request_t r);
    int unsigned gap;
    gap = sender_bursts ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.func       <= r.func;
    req_if.value      <= r.value;
    req_if.tag_first  <= r.tag_first;
    req_if.tag_second <= r.tag_second;
    req_if.read_index <= r.read_index;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    tracker.note_request(r);
  endtask

  // Drop valid and wait for every outstanding response
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Write capacity then mode, back to back, over APB
  task automatic configure(logic [CountW-1:0] cap, logic smallest);
    reg_e              idx;
    logic [PdataW-1:0] data;
    for (int i = 0; i < 2; i++) begin
      if (i == 0) begin
        idx  = REG_CAPACITY;
        data = PdataW'(cap);
      end else begin
        idx  = REG_MODE;
        data = PdataW'(smallest);
      end
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (pready !== 1'b1) @(posedge clk_i);
      tracker.write_register(idx, data);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic list_request_t random_request(int unsigned clear_pct);
    list_request_t r;
    int unsigned   pick;
    pick = $urandom_range(0, 99);
    // bias keys toward ties and extremes
    case ($urandom_range(0, 9))
      0, 1, 2: r.value = $signed($urandom_range(0, 8)) - 4;
      3: begin
        case ($urandom_range(0, 3))
          0:       r.value = 32'sh7fffffff;
          1:       r.value = 32'sh80000000;
          2:       r.value = '0;
          default: r.value = -1;
        endcase
      end
      default: r.value = $urandom();
    endcase
    r.tag_first  = TagW'($urandom_range(0, 65535));
    r.tag_second = TagW'($urandom_range(0, 65535));
    if (tracker.held > 0 && $urandom_range(0, 2) != 0)
      r.read_index = RidxW'($urandom_range(0, tracker.held - 1));
    else
      r.read_index = RidxW'($urandom_range(0, 63));
    if (pick < clear_pct) r.func = FUNC_CLEAR;
    else if (pick < clear_pct + 2) r.func = FuncNoop;
    else if (pick < 30) r.func = FUNC_READ;
    else r.func = FUNC_INSERT;
    return r;
  endfunction

  task automatic run_directed();
    // extremes, ties, reads, inserts and a no-op at reset settings
    send_request(make_request(FUNC_READ, 0, 0, 0, 0));
    send_request(make_request(FUNC_INSERT, 0, 16'h0000, 16'h0000, 0));
    send_request(make_request(FUNC_INSERT, 32'sh7fffffff, 16'hffff, 16'hffff, 6'h3f));
    send_request(make_request(FUNC_INSERT, 32'sh80000000, 16'h1234, 16'habcd, 0));
    send_request(make_request(FUNC_INSERT, 0, 16'h0001, 16'h0002, 0));
    send_request(make_request(FUNC_INSERT, -1, 16'h5555, 16'haaaa, 0));
    for (int i = 0; i < 5; i++) send_request(make_request(FUNC_READ, 0, 0, 0, RidxW'(i)));
    send_request(make_request(FUNC_READ, 0, 0, 0, 6'h3f));
    send_request(make_request(FuncNoop, 32'sh12345678, 16'hffff, 16'hffff, 6'h3f));
    // lower capacity below the held count
    wait_drained();
    configure(7'd3, 1'b0);
    send_request(make_request(FUNC_INSERT, 5, 16'h0bad, 16'hcafe, 0));
    send_request(make_request(FUNC_INSERT, 32'sh80000000, 16'h0001, 16'h0001, 0));
    send_request(make_request(FUNC_READ, 0, 0, 0, 4));
    // flip to smallest mode with entries still held
    wait_drained();
    configure(7'd3, 1'b1);
    send_request(make_request(FUNC_INSERT, -5, 16'h00ff, 16'hff00, 0));
    send_request(make_request(FUNC_READ, 0, 0, 0, 0));
    // capacity zero behaves as one
    wait_drained();
    configure(7'd0, 1'b1);
    send_request(make_request(FUNC_CLEAR, 0, 0, 0, 0));
    send_request(make_request(FUNC_INSERT, 7, 16'h0007, 16'h0070, 0));
    send_request(make_request(FUNC_INSERT, 9, 16'h0009, 16'h0090, 0));
    send_request(make_request(FUNC_INSERT, 3, 16'h0003, 16'h0030, 0));
    send_request(make_request(FUNC_READ, 0, 0, 0, 0));
  endtask

  task automatic run_random();
    logic [CountW-1:0] fixed_caps [6];
    logic [CountW-1:0] cap;
    logic              smallest;
    int unsigned       clear_pct;
    fixed_caps = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd65, 7'd63};
    for (int ph = 0; ph < Phases; ph++) begin
      wait_drained();
      if (ph < 6) begin
        cap      = fixed_caps[ph];
        smallest = ph[0];
      end else begin
        cap      = CountW'($urandom_range(0, 127));
        smallest = 1'($urandom_range(0, 1));
      end
      configure(cap, smallest);
      sender_bursts = (ph % 3 == 1);
      // rare clears let large lists fill up
      clear_pct = (cap >= 32) ? 1 : 4;
      for (int n = 0; n < PhaseRequests; n++) send_request(random_request(clear_pct));
    end
  endtask

  // Main sequence: reset, directed, random, drain, verdict
  initial begin
    tracker = new;
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    req_if.valid      <= 1'b0;
    req_if.func       <= '0;
    req_if.value      <= '0;
    req_if.tag_first  <= '0;
    req_if.tag_second <= '0;
    req_if.read_index <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
      $display("bounded_top_k_sorted_list: match");
    end else begin
      $display("bounded_top_k_sorted_list: mismatch");
    end
    $finish;
  end

  // Response side: random ready gaps, two long hold-offs to back up the input
  initial begin : response_side
    int unsigned  taken;
    int unsigned  gap;
    list_result_t got;
    taken = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = ((taken / 100) % 3 == 2) ? 0 : $urandom_range(0, 8);
      if (taken == 200 || taken == 900) gap = HoldCycles;
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (rsp_if.valid !== 1'b1) @(posedge clk_i);
      got.accepted        = rsp_if.accepted;
      got.position        = rsp_if.position;
      got.count           = rsp_if.count;
      got.read_valid      = rsp_if.read_valid;
      got.read_value      = rsp_if.read_value;
      got.read_tag_first  = rsp_if.read_tag_first;
      got.read_tag_second = rsp_if.read_tag_second;
      tracker.check_response(got);
      taken++;
    end
  end

  // Watchdog
  initial begin
    #(20_000_000);
    $display("bounded_top_k_sorted_list: mismatch");
    $finish;
  end

endmodule
